FILE: hw/rtl/u2r_pkg.sv
// Shared types, widths and conversion tables for the UYVY to RGB565 rotate core.
// Chroma term tables are built at elaboration from the fixed-point coefficients.
// No dependencies.
`timescale 1ns / 1ps

package u2r_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int PIX_W   = 16;
    localparam int ADDR_W  = 22;
    localparam int CFG_W   = 12;
    localparam int CFG_IDX_W = 2;

    // Default largest frame dimension
    localparam int MAX_DIM_DEF = 2048;

    // Register reset values
    localparam logic [CFG_W-1:0] COLUMNS_RST = 12'd144;
    localparam logic [CFG_W-1:0] ROWS_RST    = 12'd176;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_ROWS    = 2'd1;

    // Conversion coefficients, scaled by CONV_DIV
    localparam int CONV_DIV = 1000000;
    localparam int R_V_K    = 1370705;
    localparam int G_V_K    = 698001;
    localparam int G_U_K    = 337633;
    localparam int B_U_K    = 1732446;
    localparam int CHROMA_OFS = 128;
    localparam int LUMA_OFS   = 16;

    // Chroma term: (byte - 128) * k / CONV_DIV, truncated toward zero
    localparam int TERM_W = 10;
    typedef logic signed [TERM_W-1:0] t_term;
    typedef t_term t_term_tab [256];

    // Per-pixel channel sum width (luma plus terms, signed)
    localparam int SUM_W = 11;
    typedef logic signed [SUM_W-1:0] t_sum;

    // Address generator result for one transaction
    typedef struct packed {
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
        logic              frame_done;
    } t_addr_res;

    function automatic t_term_tab build_tab(input int k);
        t_term_tab tab;
        int        v;
        for (int b = 0; b < 256; b++) begin
            v      = b - CHROMA_OFS;
            tab[b] = t_term'((v * k) / CONV_DIV);
        end
        return tab;
    endfunction

    localparam t_term_tab R_V_TAB = build_tab(R_V_K);
    localparam t_term_tab G_V_TAB = build_tab(G_V_K);
    localparam t_term_tab G_U_TAB = build_tab(G_U_K);
    localparam t_term_tab B_U_TAB = build_tab(B_U_K);

endpackage

FILE: hw/rtl/u2r_pixel_conv.sv
// One pixel of YUV to RGB565 conversion with per-channel saturation.
// Depends on u2r_pkg for the chroma term tables.
`timescale 1ns / 1ps

module u2r_pixel_conv (
    input  logic [u2r_pkg::BYTE_W-1:0] i_y,
    input  logic [u2r_pkg::BYTE_W-1:0] i_u,
    input  logic [u2r_pkg::BYTE_W-1:0] i_v,
    output logic [u2r_pkg::PIX_W-1:0]  o_pixel
);
    import u2r_pkg::*;

    localparam t_sum Y_OFS = t_sum'(LUMA_OFS);

    t_sum              y_s;
    t_sum              r_sum;
    t_sum              g_sum;
    t_sum              b_sum;
    logic [BYTE_W-1:0] r_ch;
    logic [BYTE_W-1:0] g_ch;
    logic [BYTE_W-1:0] b_ch;

    function automatic logic [BYTE_W-1:0] sat8(input t_sum x);
        logic [BYTE_W-1:0] res;
        if (x < 0) begin
            res = '0;
        end else if (x > t_sum'(255)) begin
            res = '1;
        end else begin
            res = x[BYTE_W-1:0];
        end
        return res;
    endfunction

    // Remove luma offset and add or subtract the chroma terms from the tables
    assign y_s   = signed'({3'b000, i_y}) - Y_OFS;
    assign r_sum = y_s + t_sum'(R_V_TAB[i_v]);
    assign g_sum = y_s - t_sum'(G_V_TAB[i_v]) - t_sum'(G_U_TAB[i_u]);
    assign b_sum = y_s + t_sum'(B_U_TAB[i_u]);

    // Saturate and pack 5/6/5
    assign r_ch    = sat8(r_sum);
    assign g_ch    = sat8(g_sum);
    assign b_ch    = sat8(b_sum);
    assign o_pixel = {r_ch[7:3], g_ch[7:2], b_ch[7:3]};

endmodule

FILE: hw/rtl/u2r_addr_gen.sv
// Rotated-frame write address generator: walks columns last to first,
// rows top to bottom, two rows per transaction. Depends on u2r_pkg.
`timescale 1ns / 1ps

module u2r_addr_gen #(
    parameter int MAX_DIM = u2r_pkg::MAX_DIM_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [u2r_pkg::CFG_W-1:0] i_columns,
    input  logic [u2r_pkg::CFG_W-1:0] i_rows,
    input  logic                      i_adv,
    output u2r_pkg::t_addr_res        o_res
);
    import u2r_pkg::*;

    localparam int PW = $clog2(MAX_DIM);
    localparam int EW = PW + 1;
    localparam int MW = PW + EW + 1;
    localparam logic [EW-1:0] MAX_COLS = EW'(MAX_DIM);
    localparam logic [EW-1:0] MAX_ROWS = EW'(MAX_DIM & ~1);

    logic [PW-1:0] r_column_step;
    logic [PW-1:0] r_row_position;
    logic [PW-1:0] n_column_step;
    logic [PW-1:0] n_row_position;

    logic [EW-1:0] cols;
    logic [EW-1:0] rows;
    logic [CFG_W-1:0] rows_even;
    logic          restart;
    logic [PW-1:0] cs;
    logic [PW-1:0] rp;
    logic [EW-1:0] col;
    logic [EW-1:0] rp2;
    logic [EW-1:0] cs1;
    logic [MW-1:0] addr_a_w;
    logic [MW-1:0] addr_b_w;

    // Clamp configured dimensions into the legal range
    always_comb begin
        rows_even = i_rows & ~CFG_W'(1);
        if (i_columns == '0) begin
            cols = EW'(1);
        end else if (32'(i_columns) > 32'(MAX_DIM)) begin
            cols = MAX_COLS;
        end else begin
            cols = EW'(i_columns);
        end
        if (rows_even < CFG_W'(2)) begin
            rows = EW'(2);
        end else if (32'(rows_even) > 32'(MAX_DIM)) begin
            rows = MAX_ROWS;
        end else begin
            rows = EW'(rows_even);
        end
    end

    // Restart the frame if the position fell outside it, then form addresses
    always_comb begin
        restart  = (EW'(r_column_step) >= cols) || (EW'(r_row_position) + EW'(1) >= rows);
        cs       = restart ? '0 : r_column_step;
        rp       = restart ? '0 : r_row_position;
        col      = cols - EW'(1) - EW'(cs);
        addr_a_w = MW'(rp) * MW'(cols) + MW'(col);
        addr_b_w = addr_a_w + MW'(cols);
        rp2      = EW'(rp) + EW'(2);
        cs1      = EW'(cs) + EW'(1);

        n_row_position   = PW'(rp2);
        n_column_step    = cs;
        o_res.frame_done = 1'b0;
        if (rp2 >= rows) begin
            n_row_position = '0;
            if (cs1 >= cols) begin
                n_column_step    = '0;
                o_res.frame_done = 1'b1;
            end else begin
                n_column_step = PW'(cs1);
            end
        end
        o_res.addr_a = ADDR_W'(addr_a_w);
        o_res.addr_b = ADDR_W'(addr_b_w);
    end

    // Advance position on each transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_step  <= '0;
            r_row_position <= '0;
        end else if (i_adv) begin
            r_column_step  <= n_column_step;
            r_row_position <= n_row_position;
        end
    end

endmodule

FILE: hw/rtl/uyvy_to_rgb565_rotate_core.sv
// UYVY to RGB565 converter with rotated-frame write addresses.
// Pipeline: input register, then result register. Throughput: one macropixel per cycle
// while the output is not stalled, set by the single-pass conversion and address path.
// Reset (synchronous, active low) clears both pipeline valids, restarts the frame at the
// last column, top row, and loads 144 columns by 176 rows.
`timescale 1ns / 1ps

module uyvy_to_rgb565_rotate_core #(
    parameter int MAX_DIM = u2r_pkg::MAX_DIM_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [u2r_pkg::BYTE_W-1:0]    i_u_byte,
    input  logic [u2r_pkg::BYTE_W-1:0]    i_y0_byte,
    input  logic [u2r_pkg::BYTE_W-1:0]    i_v_byte,
    input  logic [u2r_pkg::BYTE_W-1:0]    i_y1_byte,
    // Output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [u2r_pkg::PIX_W-1:0]     o_pixel_a,
    output logic [u2r_pkg::PIX_W-1:0]     o_pixel_b,
    output logic [u2r_pkg::ADDR_W-1:0]    o_address_a,
    output logic [u2r_pkg::ADDR_W-1:0]    o_address_b,
    output logic                          o_frame_done,
    // Configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [u2r_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [u2r_pkg::CFG_W-1:0]     i_cfg_data
);
    import u2r_pkg::*;

    logic [CFG_W-1:0]  r_out_columns;
    logic [CFG_W-1:0]  r_out_rows;

    logic              r_s1_valid;
    logic              n_s1_valid;
    logic [BYTE_W-1:0] r_u;
    logic [BYTE_W-1:0] r_y0;
    logic [BYTE_W-1:0] r_v;
    logic [BYTE_W-1:0] r_y1;

    logic              r_out_valid;
    logic              n_out_valid;
    logic [PIX_W-1:0]  r_pixel_a;
    logic [PIX_W-1:0]  r_pixel_b;
    logic [ADDR_W-1:0] r_address_a;
    logic [ADDR_W-1:0] r_address_b;
    logic              r_frame_done;

    logic              s2_free;
    logic              s1_adv;
    logic              s1_free;
    logic              in_take;
    logic [PIX_W-1:0]  pix_a;
    logic [PIX_W-1:0]  pix_b;
    t_addr_res         addr_res;

    // Configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_columns <= COLUMNS_RST;
            r_out_rows    <= ROWS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OUT_COLUMNS: r_out_columns <= i_cfg_data;
                CFG_OUT_ROWS:    r_out_rows    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline flow control
    assign s2_free     = !r_out_valid || !i_out_stall;
    assign s1_adv      = r_s1_valid && s2_free;
    assign s1_free     = !r_s1_valid || s2_free;
    assign in_take     = i_in_valid && s1_free;
    assign o_in_stall  = !s1_free;
    assign n_s1_valid  = in_take || (r_s1_valid && !s2_free);
    assign n_out_valid = s1_adv || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the input transaction
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_u  <= i_u_byte;
            r_y0 <= i_y0_byte;
            r_v  <= i_v_byte;
            r_y1 <= i_y1_byte;
        end
    end

    // Color conversion, one unit per pixel sharing chroma
    u2r_pixel_conv u_conv_a (
        .i_y     (r_y0),
        .i_u     (r_u),
        .i_v     (r_v),
        .o_pixel (pix_a)
    );

    u2r_pixel_conv u_conv_b (
        .i_y     (r_y1),
        .i_u     (r_u),
        .i_v     (r_v),
        .o_pixel (pix_b)
    );

    // Rotated addresses, advanced as each item leaves the input register
    u2r_addr_gen #(
        .MAX_DIM (MAX_DIM)
    ) u_addr_gen (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_columns (r_out_columns),
        .i_rows    (r_out_rows),
        .i_adv     (s1_adv),
        .o_res     (addr_res)
    );

    // Result register, hold while stalled
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_pixel_a    <= pix_a;
            r_pixel_b    <= pix_b;
            r_address_a  <= addr_res.addr_a;
            r_address_b  <= addr_res.addr_b;
            r_frame_done <= addr_res.frame_done;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_a    = r_pixel_a;
    assign o_pixel_b    = r_pixel_b;
    assign o_address_a  = r_address_a;
    assign o_address_b  = r_address_b;
    assign o_frame_done = r_frame_done;

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for uyvy_to_rgb565_rotate_core: UYVY macropixels in, RGB565 pairs
// with rotated-frame addresses out, checked against an in-bench conversion and address walk.
// Depends on u2r_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_top;
    import u2r_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_LEN    = 300;
    localparam int PRINT_CAP   = 40;
    localparam int DIM_MAX     = MAX_DIM_DEF;
    localparam int NUM_PHASES  = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] u;
        logic [BYTE_W-1:0] y0;
        logic [BYTE_W-1:0] v;
        logic [BYTE_W-1:0] y1;
    } t_macropixel;

    typedef struct packed {
        logic [PIX_W-1:0]  pixel_a;
        logic [PIX_W-1:0]  pixel_b;
        logic [ADDR_W-1:0] address_a;
        logic [ADDR_W-1:0] address_b;
        logic              frame_done;
    } t_rotated_px;

    // Clock, reset and block inputs, all known from time zero
    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              in_valid  = 1'b0;
    t_macropixel       cur_mp    = '0;
    logic              out_stall = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data  = '0;

    wire               in_stall;
    wire               out_valid;
    wire [PIX_W-1:0]   o_pixel_a;
    wire [PIX_W-1:0]   o_pixel_b;
    wire [ADDR_W-1:0]  o_address_a;
    wire [ADDR_W-1:0]  o_address_b;
    wire               o_frame_done;
    wire               o_cfg_ready;

    // Stimulus and expectation stores
    t_macropixel       macropixel_q[$];
    t_rotated_px       rotated_q[$];

    // Predictor copy of registers and frame position
    logic [CFG_W-1:0]  cols_reg = COLUMNS_RST;
    logic [CFG_W-1:0]  rows_reg = ROWS_RST;
    int                col_step = 0;
    int                row_pos  = 0;

    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    logic              hold_go     = 1'b0;
    logic              holding     = 1'b0;
    int                hold_cycles = 0;
    int                err_count   = 0;
    int                cycle_count = 0;

    uyvy_to_rgb565_rotate_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_u_byte     (cur_mp.u),
        .i_y0_byte    (cur_mp.y0),
        .i_v_byte     (cur_mp.v),
        .i_y1_byte    (cur_mp.y1),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_pixel_a    (o_pixel_a),
        .o_pixel_b    (o_pixel_b),
        .o_address_a  (o_address_a),
        .o_address_b  (o_address_b),
        .o_frame_done (o_frame_done),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic int clamp255(input int x);
        if (x < 0) return 0;
        if (x > 255) return 255;
        return x;
    endfunction

    function automatic logic [PIX_W-1:0] rgb565_of(input int luma, input int cb, input int cr);
        int red;
        int grn;
        int blu;
        red = clamp255(luma + (cr * R_V_K) / CONV_DIV);
        grn = clamp255(luma - (cr * G_V_K) / CONV_DIV - (cb * G_U_K) / CONV_DIV);
        blu = clamp255(luma + (cb * B_U_K) / CONV_DIV);
        return {red[7:3], grn[7:2], blu[7:3]};
    endfunction

    // Convert one macropixel and step the column-major rotated walk
    function automatic t_rotated_px predict_rotated(input t_macropixel mp);
        int          ncols;
        int          nrows;
        int          col;
        int          cb;
        int          cr;
        t_rotated_px res;
        ncols = cols_reg;
        if (ncols < 1) ncols = 1;
        if (ncols > DIM_MAX) ncols = DIM_MAX;
        nrows = rows_reg & 12'hFFE;
        if (nrows < 2) nrows = 2;
        if (nrows > DIM_MAX) nrows = DIM_MAX & ~1;
        // restart when a register change left the position outside the frame
        if (col_step >= ncols || row_pos + 1 >= nrows) begin
            col_step = 0;
            row_pos  = 0;
        end
        col = ncols - 1 - col_step;
        cb  = int'(mp.u) - CHROMA_OFS;
        cr  = int'(mp.v) - CHROMA_OFS;
        res.pixel_a   = rgb565_of(int'(mp.y0) - LUMA_OFS, cb, cr);
        res.pixel_b   = rgb565_of(int'(mp.y1) - LUMA_OFS, cb, cr);
        res.address_a = ADDR_W'(row_pos * ncols + col);
        res.address_b = ADDR_W'((row_pos + 1) * ncols + col);
        res.frame_done = 1'b0;
        row_pos += 2;
        if (row_pos >= nrows) begin
            row_pos = 0;
            col_step++;
            if (col_step >= ncols) begin
                col_step = 0;
                res.frame_done = 1'b1;
            end
        end
        return res;
    endfunction

    // Bias toward saturation and offset corners
    function automatic logic [BYTE_W-1:0] pick_byte();
        logic [BYTE_W-1:0] corners[6] = '{8'd0, 8'd255, 8'd16, 8'd128, 8'd235, 8'd240};
        if ($urandom_range(7) == 0) return corners[$urandom_range(5)];
        return BYTE_W'($urandom_range(255));
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < PRINT_CAP)
            $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
        err_count++;
    endtask

    // Wait until every queued macropixel is taken and every result has come
    task automatic wait_drained();
        do @(posedge i_clk);
        while (macropixel_q.size() != 0 || in_valid || rotated_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_OUT_COLUMNS) cols_reg = data;
        else if (idx == CFG_OUT_ROWS) rows_reg = data;
        @(posedge i_clk);
    endtask

    // Driver: offer queued macropixels, predict on each accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            col_step = 0;
            row_pos  = 0;
        end else begin
            if (in_valid && !in_stall)
                rotated_q.push_back(predict_rotated(cur_mp));
            if (!in_valid || !in_stall) begin
                if (macropixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_mp   <= macropixel_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            holding     <= 1'b0;
            hold_cycles <= 0;
        end else if (hold_go && !holding) begin
            holding     <= 1'b1;
            hold_cycles <= 0;
        end else if (holding) begin
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles == HOLD_LEN - 1) holding <= 1'b0;
        end
    end

    // Monitor: compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_rotated_px want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (rotated_q.size() == 0) begin
                    report_mismatch("unexpected result", 32'(o_address_a), 32'(0));
                end else begin
                    want = rotated_q.pop_front();
                    if (o_pixel_a !== want.pixel_a)
                        report_mismatch("pixel_a", 32'(o_pixel_a), 32'(want.pixel_a));
                    if (o_pixel_b !== want.pixel_b)
                        report_mismatch("pixel_b", 32'(o_pixel_b), 32'(want.pixel_b));
                    if (o_address_a !== want.address_a)
                        report_mismatch("address_a", 32'(o_address_a), 32'(want.address_a));
                    if (o_address_b !== want.address_b)
                        report_mismatch("address_b", 32'(o_address_b), 32'(want.address_b));
                    if (o_frame_done !== want.frame_done)
                        report_mismatch("frame_done", 32'(o_frame_done),
                                        32'(want.frame_done));
                end
            end
            out_stall <= holding || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        logic [31:0] directed[16] = '{
            32'h00000000, 32'hFFFFFFFF, 32'h80108010, 32'h80EB80EB,
            32'h00FF00FF, 32'hFF00FF00, 32'h80FFFF00, 32'h80000000,
            32'hFFFF80FF, 32'h00008000, 32'hAA55AA55, 32'h55AA55AA,
            32'h7F81817F, 32'h81107F10, 32'h7FEB7FEB, 32'h01FE01FE
        };
        // columns, rows, sender idle %, receiver stall %, items, long hold-off
        int ph_cols[NUM_PHASES]  = '{1, 0, 3, 5, 4095, 2048, 7, 2, 16, 6};
        int ph_rows[NUM_PHASES]  = '{2, 0, 6, 7, 4095, 2, 4, 10, 2050, 8};
        int ph_send[NUM_PHASES]  = '{0, 69, 0, 35, 0, 69, 0, 35, 0, 35};
        int ph_recv[NUM_PHASES]  = '{0, 0, 69, 35, 0, 0, 0, 35, 69, 35};
        int ph_items[NUM_PHASES] = '{40, 40, 60, 60, 30, 40, 80, 60, 40, 150};
        bit ph_hold[NUM_PHASES]  = '{0, 0, 0, 0, 0, 0, 1, 0, 0, 0};
        t_macropixel mp;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners at the reset frame size
        foreach (directed[k]) macropixel_q.push_back(t_macropixel'(directed[k]));
        wait_drained();

        // A write to an unmapped index must change nothing
        write_reg(CFG_UNUSED, '1);

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(CFG_OUT_COLUMNS, CFG_W'(ph_cols[p]));
            write_reg(CFG_OUT_ROWS, CFG_W'(ph_rows[p]));
            send_idle_pct  <= ph_send[p];
            recv_stall_pct <= ph_recv[p];
            for (int n = 0; n < ph_items[p]; n++) begin
                mp.u  = pick_byte();
                mp.y0 = pick_byte();
                mp.v  = pick_byte();
                mp.y1 = pick_byte();
                macropixel_q.push_back(mp);
            end
            hold_go <= ph_hold[p];
            @(posedge i_clk);
            hold_go <= 1'b0;
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (rotated_q.size() != 0)
            report_mismatch("missing results", 32'(rotated_q.size()), 32'(0));
        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
